@@ rtl/aeve_pkg.sv @@
// Shared types and constants for the absolute encoder velocity estimator.
// Used by the controller, the datapath, the top level and the port checker.
// Depends on nothing else.
package aeve_pkg;

  // Default count resolution of the encoder.
  localparam int COUNT_BITS_DEF = 12;

  // Field widths of the item channels.
  localparam int FRAME_W    = 8;
  localparam int ELAPSED_W  = 32;
  localparam int RAW_W      = 12;
  localparam int VEL_W      = 32;
  localparam int IN_DATA_W  = 2 * FRAME_W + ELAPSED_W;
  localparam int OUT_DATA_W = 2 * RAW_W + VEL_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int WEIGHT_W   = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_OFFSET = 2'd0,
    REG_FILTER_WEIGHT  = 2'd1,
    REG_MIN_ELAPSED    = 2'd2
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic [RAW_W-1:0]     INIT_OFFSET_RST = 12'd0;
  localparam logic [WEIGHT_W-1:0]  WEIGHT_RST      = 17'd6554;
  localparam logic [ELAPSED_W-1:0] MIN_ELAPSED_RST = 32'd1;

  // Filter weight of one, unsigned Q1.16.
  localparam logic [WEIGHT_W-1:0] W_ONE = 17'd65536;

  // Item kind carried on the input tuser.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_REZERO = 1'b1;

  // Nanoseconds per second, the speed scale before the Q.8 shift.
  localparam int NS_W = 30;
  localparam logic [NS_W-1:0] NS_PER_S = 30'd1000000000;

  // Quotient bits that the divider resolves; larger quotients saturate.
  localparam int DIV_STEPS = 31;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int Q8_SHIFT  = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic calc_pos;
    logic mul;
    logic div_init;
    logic div_step;
    logic spd;
    logic ema_mul;
    logic ema_add;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic upd;
    logic out_free;
  } dp_sts_t;

endpackage

@@ rtl/absolute_encoder_velocity_estimator.sv @@
// Absolute encoder velocity estimator. One input item is a two-byte 12-bit
// encoder frame plus the nanoseconds since the previous frame; one result
// item comes back for each. A sample item that updates the speed goes from
// acceptance to a valid result through unpack, one multiply by 1e9, divider
// setup, 31 steps of the restoring divider, the speed, filter multiply and
// filter add steps and the output load. A rezero item or a sample whose
// elapsed time does not exceed min_elapsed goes from unpack straight to the
// output load. The input reopens in the cycle after the result is loaded, and
// a result stalled in the output register holds back the load of the next
// one. One item is in work at a time. Configuration writes are always
// accepted and must come only while the block is idle.
// Depends on aeve_pkg, aeve_ctrl and aeve_dp.
module absolute_encoder_velocity_estimator #(
  parameter int COUNT_BITS = aeve_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input item.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // frame_high [7:0], frame_low [15:8], elapsed_ns [47:16]
  input  logic [aeve_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd [0]
  input  logic                            in_tuser,
  // Result item.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // raw_count [11:0], position_count [23:12], velocity_q8 [55:24]
  output logic [aeve_pkg::OUT_DATA_W-1:0] out_tdata,
  // velocity_updated [0]
  output logic                            out_tuser,
  // Configuration writes.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [aeve_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aeve_pkg::CFG_DATA_W-1:0] cfg_data
);
  import aeve_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  // Sequencing controller.
  aeve_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and storage.
  aeve_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ rtl/aeve_ctrl.sv @@
// Sequencing controller of the velocity estimator.
// Steps the datapath through unpack, multiply, divide and filter.
// Depends on aeve_pkg.
module aeve_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  aeve_pkg::dp_sts_t sts,
  output aeve_pkg::dp_cmd_t cmd
);
  import aeve_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS,
    S_MUL,
    S_CHK,
    S_DIV,
    S_SPD,
    S_EMUL,
    S_EADD,
    S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 ready_r, ready_nxt;
  logic                 accept;

  assign accept    = in_tvalid && ready_r;
  assign in_tready = ready_r;

  // Next state and step counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        state_nxt = sts.upd ? S_MUL : S_DONE;
      end
      S_MUL: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = S_DIV;
        cnt_nxt   = '0;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_SPD;
        end
      end
      S_SPD: begin
        state_nxt = S_EMUL;
      end
      S_EMUL: begin
        state_nxt = S_EADD;
      end
      S_EADD: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    ready_nxt = (state_nxt == S_IDLE);
  end

  // State, counter and the registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ready_r <= ready_nxt;
    end
  end

  // Datapath commands decoded from the state.
  always_comb begin
    cmd          = '0;
    cmd.load_in  = accept;
    cmd.calc_pos = (state_r == S_POS);
    cmd.mul      = (state_r == S_MUL);
    cmd.div_init = (state_r == S_CHK);
    cmd.div_step = (state_r == S_DIV);
    cmd.spd      = (state_r == S_SPD);
    cmd.ema_mul  = (state_r == S_EMUL);
    cmd.ema_add  = (state_r == S_EADD);
    cmd.load_out = (state_r == S_DONE) && sts.out_free;
  end

endmodule

@@ rtl/aeve_dp.sv @@
// Datapath of the velocity estimator: configuration and state registers,
// position unwrap, speed multiply and restoring divider, exponential moving average and
// the output register. Depends on aeve_pkg.
module aeve_dp #(
  parameter int COUNT_BITS = aeve_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  aeve_pkg::dp_cmd_t                   cmd,
  output aeve_pkg::dp_sts_t                   sts,
  input  logic [aeve_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tuser,
  input  logic                                cfg_valid,
  input  logic [aeve_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aeve_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [aeve_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tuser
);
  import aeve_pkg::*;

  localparam int PROD_W = COUNT_BITS + NS_W;
  localparam int LOW_W  = DIV_STEPS - Q8_SHIFT;
  localparam logic [COUNT_BITS-1:0] HALF_TURN = COUNT_BITS'(1) << (COUNT_BITS - 1);

  // Configuration and persistent state.
  logic [WEIGHT_W-1:0]    weight_r;
  logic [ELAPSED_W-1:0]   min_el_r;
  logic [COUNT_BITS-1:0]  zero_off_r;
  logic [COUNT_BITS-1:0]  last_r;
  logic signed [VEL_W-1:0] filt_r;

  // Latched input item.
  logic                   kind_r;
  logic [FRAME_W-1:0]     hi_r;
  logic [FRAME_W-1:0]     lo_r;
  logic [ELAPSED_W-1:0]   el_r;

  // Working registers.
  logic [COUNT_BITS-1:0]  raw_r;
  logic [COUNT_BITS-1:0]  pos_r;
  logic [COUNT_BITS-1:0]  mag_r;
  logic                   neg_r;
  logic                   upd_r;
  logic [PROD_W-1:0]      prod_r;
  logic                   ovf_r;
  logic [ELAPSED_W-1:0]   rem_r;
  logic [DIV_STEPS-1:0]   q_r;
  logic signed [VEL_W-1:0] v_r;
  logic signed [VEL_W+WEIGHT_W+1:0] emprod_r;

  // Output register.
  logic                   out_valid_r;
  logic [RAW_W-1:0]       out_raw_r;
  logic [RAW_W-1:0]       out_pos_r;
  logic [VEL_W-1:0]       out_vel_r;
  logic                   out_upd_r;

  // Combinational terms.
  logic [RAW_W-1:0]        raw12;
  logic [COUNT_BITS-1:0]   raw_cb;
  logic [COUNT_BITS-1:0]   pos;
  logic [COUNT_BITS:0]     diff;
  logic                    dneg;
  logic [COUNT_BITS-1:0]   adiff;
  logic                    wrap;
  logic                    upd_now;
  logic [PROD_W-LOW_W-1:0] top;
  logic [ELAPSED_W:0]      trial;
  logic                    ge;
  logic signed [VEL_W:0]   vdiff;
  logic signed [WEIGHT_W:0] wsg;
  logic [WEIGHT_W-1:0]     wclip;
  logic signed [VEL_W+WEIGHT_W+1:0] ema_sum;
  logic signed [VEL_W+WEIGHT_W+1:0] ema_sh;

  // Unpack the frame and find the shortest signed change.
  always_comb begin
    raw12 = {hi_r[6:0], lo_r[7:3]};
    raw_cb = COUNT_BITS'(raw12);
    pos   = raw_cb - zero_off_r;
    diff  = {1'b0, pos} - {1'b0, last_r};
    dneg  = diff[COUNT_BITS];
    adiff = dneg ? COUNT_BITS'(-diff) : diff[COUNT_BITS-1:0];
    wrap  = adiff > HALF_TURN;
    // The speed is recomputed only for a sample item past the time threshold.
    upd_now = (kind_r == CMD_SAMPLE) && (el_r > min_el_r);
  end

  // Divider: top of the scaled dividend and one restoring step.
  always_comb begin
    top   = prod_r[PROD_W-1:LOW_W];
    trial = {rem_r, q_r[DIV_STEPS-1]};
    ge    = trial >= {1'b0, el_r};
  end

  // Exponential-average terms: weight clipped to one, the difference, and the rounded, shifted product.
  always_comb begin
    wclip   = (weight_r > W_ONE) ? W_ONE : weight_r;
    wsg     = signed'({1'b0, wclip});
    vdiff   = {v_r[VEL_W-1], v_r} - {filt_r[VEL_W-1], filt_r};
    ema_sum = emprod_r + 51'sd32768;
    ema_sh  = ema_sum >>> 16;
  end

  // Configuration registers and the zero offset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r   <= WEIGHT_RST;
      min_el_r   <= MIN_ELAPSED_RST;
      zero_off_r <= COUNT_BITS'(INIT_OFFSET_RST);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INITIAL_OFFSET: begin
          zero_off_r <= COUNT_BITS'(cfg_data[RAW_W-1:0]);
        end
        REG_FILTER_WEIGHT: begin
          weight_r <= cfg_data[WEIGHT_W-1:0];
        end
        REG_MIN_ELAPSED: begin
          min_el_r <= cfg_data[ELAPSED_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (cmd.calc_pos && kind_r == CMD_REZERO) begin
      zero_off_r <= raw_cb;
    end
  end

  // Position and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      filt_r <= '0;
    end else if (cmd.calc_pos) begin
      if (kind_r == CMD_REZERO) begin
        last_r <= '0;
        filt_r <= '0;
      end else begin
        last_r <= pos;
      end
    end else if (cmd.ema_add) begin
      filt_r <= filt_r + signed'(ema_sh[VEL_W-1:0]);
    end
  end

  // Input latch and the working registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= in_tuser;
      hi_r   <= in_tdata[FRAME_W-1:0];
      lo_r   <= in_tdata[2*FRAME_W-1:FRAME_W];
      el_r   <= in_tdata[IN_DATA_W-1:2*FRAME_W];
    end
    if (cmd.calc_pos) begin
      raw_r <= raw_cb;
      pos_r <= (kind_r == CMD_REZERO) ? '0 : pos;
      mag_r <= wrap ? COUNT_BITS'(0) - adiff : adiff;
      neg_r <= wrap ? !dneg : dneg;
      upd_r <= upd_now;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(mag_r) * PROD_W'(NS_PER_S);
    end
    if (cmd.div_init) begin
      ovf_r <= ELAPSED_W'(top) >= el_r;
      rem_r <= ELAPSED_W'(top);
      q_r   <= {prod_r[LOW_W-1:0], {Q8_SHIFT{1'b0}}};
    end else if (cmd.div_step) begin
      rem_r <= ge ? ELAPSED_W'(trial - {1'b0, el_r}) : trial[ELAPSED_W-1:0];
      q_r   <= {q_r[DIV_STEPS-2:0], ge};
    end
    if (cmd.spd) begin
      if (ovf_r) begin
        v_r <= neg_r ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
      end else begin
        v_r <= neg_r ? -signed'({1'b0, q_r}) : signed'({1'b0, q_r});
      end
    end
    if (cmd.ema_mul) begin
      emprod_r <= vdiff * wsg;
    end
  end

  // Output register; it holds a result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_raw_r <= RAW_W'(raw_r);
      out_pos_r <= RAW_W'(pos_r);
      out_vel_r <= filt_r;
      out_upd_r <= upd_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {out_vel_r, out_pos_r, out_raw_r};
  assign out_tuser    = out_upd_r;
  assign sts.upd      = upd_now;
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

@@ rtl/aeve_checker.sv @@
// Port-level checks for the velocity estimator, bound to the top level.
// Depends on aeve_pkg and absolute_encoder_velocity_estimator.
module aeve_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [aeve_pkg::OUT_DATA_W-1:0] out_tdata
);

  // One item at a time: after an item is taken, the input closes.
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready stayed high after an item was accepted");

  // No result can appear in the cycle right after an item is taken.
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared one cycle after acceptance");

  // A closed input does not reopen while a result stalls:
  // while the input is closed and the output stalls, the input stays closed.
  a_hold_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && out_tvalid && !out_tready |=> !in_tready || !out_tvalid)
    else $error("input reopened while a result was still stalled");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind absolute_encoder_velocity_estimator aeve_checker u_aeve_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
